/* hdl/dgcp_pkg.sv */
// dgcp_pkg: shared widths, constants and transaction types for the
// delta gamma curve code packer. No dependencies.
package dgcp_pkg;

    localparam int MAX_CODE_BITS = 62;
    localparam int CHUNK_WIDTH   = 64;
    localparam int CODE_W        = MAX_CODE_BITS;
    localparam int CB_W          = 6;
    localparam int VAL_W         = CODE_W + 1;
    localparam int LEN_W         = 7;
    localparam int LG_W          = 6;
    localparam int WORD_W        = 2 * CHUNK_WIDTH;
    localparam int MAX_WORD_LEN  = 2 * MAX_CODE_BITS + 1;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

    localparam logic [CB_W-1:0] CODE_BITS_RESET = CB_W'(32);

    // classified point, front to back
    typedef struct packed {
        logic              is_raw;
        logic [VAL_W-1:0]  value;
        logic [CB_W-1:0]   raw_len;
    } entry_t;

    // one output chunk
    typedef struct packed {
        logic [CHUNK_WIDTH-1:0] bits;
        logic [LEN_W-1:0]       length;
        logic                   last;
    } chunk_t;

endpackage

/* hdl/dgcp_front.sv */
// dgcp_front: holds code_bits and track state, masks each point and forms
// the raw value or the zigzag-plus-one delta. Depends on dgcp_pkg.
module dgcp_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [dgcp_pkg::CB_W-1:0]        cfg_wr_data,
    input  logic                             push,
    input  logic                             queue_full,
    input  logic [dgcp_pkg::CODE_W-1:0]      point_code,
    input  logic                             new_track,
    output logic                             entry_wr,
    output dgcp_pkg::entry_t                 entry
);

    logic [dgcp_pkg::CB_W-1:0]   code_bits_reg;
    logic [dgcp_pkg::CODE_W-1:0] previous_code_reg;
    logic                        awaiting_first_reg;

    logic [dgcp_pkg::CB_W-1:0]   nb;
    logic [dgcp_pkg::CODE_W-1:0] mask;
    logic [dgcp_pkg::CODE_W-1:0] code;
    logic [dgcp_pkg::CODE_W:0]   diff_up;
    logic [dgcp_pkg::CODE_W-1:0] diff_dn;
    logic                        is_raw;

    always_comb
    begin
        if (code_bits_reg == '0)
            nb = dgcp_pkg::CB_W'(1);
        else if (code_bits_reg > dgcp_pkg::CB_W'(dgcp_pkg::MAX_CODE_BITS))
            nb = dgcp_pkg::CB_W'(dgcp_pkg::MAX_CODE_BITS);
        else
            nb = code_bits_reg;
        mask    = ~({dgcp_pkg::CODE_W{1'b1}} << nb);
        code    = point_code & mask;
        diff_up = {1'b0, code} - {1'b0, previous_code_reg};
        diff_dn = previous_code_reg - code;
        is_raw  = awaiting_first_reg || new_track;
    end

    // forward delta maps to 2d+1, backward delta to 2|d|
    always_comb
    begin
        entry.is_raw  = is_raw;
        entry.raw_len = nb;
        if (is_raw)
            entry.value = {1'b0, code};
        else if (diff_up[dgcp_pkg::CODE_W])
            entry.value = {diff_dn, 1'b0};
        else
            entry.value = {diff_up[dgcp_pkg::CODE_W-1:0], 1'b1};
    end

    assign entry_wr = push && !queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_bits_reg      <= dgcp_pkg::CODE_BITS_RESET;
            previous_code_reg  <= '0;
            awaiting_first_reg <= 1'b1;
        end
        else
        begin
            if (cfg_wr_en)
                code_bits_reg <= cfg_wr_data;
            if (entry_wr)
            begin
                previous_code_reg  <= code;
                awaiting_first_reg <= 1'b0;
            end
        end
    end

endmodule

/* hdl/dgcp_fifo.sv */
// dgcp_fifo: short queue of classified points between front and back.
// Depends on dgcp_pkg.
module dgcp_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  dgcp_pkg::entry_t  wr_data,
    input  logic              rd_en,
    output dgcp_pkg::entry_t  rd_data,
    output logic              full,
    output logic              empty
);

    dgcp_pkg::entry_t                data_reg [dgcp_pkg::FIFO_DEPTH];
    logic [dgcp_pkg::FIFO_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [dgcp_pkg::FIFO_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [dgcp_pkg::FIFO_CW-1:0]    count_reg, count_next;

    assign full    = (count_reg == dgcp_pkg::FIFO_CW'(dgcp_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            data_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

/* hdl/dgcp_back.sv */
// dgcp_back: finds the codeword length, left-aligns it in a two-chunk word
// and emits one chunk per cycle unless pop stalls it. Depends on dgcp_pkg.
module dgcp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  dgcp_pkg::entry_t  head,
    input  logic              head_empty,
    output logic              head_pop,
    input  logic              pop,
    output logic              empty,
    output dgcp_pkg::chunk_t  chunk
);

    // floor(log2 v), two levels of eight
    function automatic logic [dgcp_pkg::LG_W-1:0] floor_log2(
        input logic [dgcp_pkg::VAL_W-1:0] v);
        logic [63:0] w;
        logic [2:0]  grp;
        logic [2:0]  pos;
        logic [7:0]  sel;
        w   = 64'(v);
        grp = '0;
        for (int g = 0; g < 8; g++)
            if (|w[g*8 +: 8])
                grp = 3'(g);
        sel = w[{grp, 3'b000} +: 8];
        pos = '0;
        for (int b = 0; b < 8; b++)
            if (sel[b])
                pos = 3'(b);
        return {grp, pos};
    endfunction

    // length stage
    logic                          s1_valid_reg;
    logic [dgcp_pkg::VAL_W-1:0]    s1_value_reg;
    logic [dgcp_pkg::LEN_W-1:0]    s1_len_reg;
    logic [dgcp_pkg::LEN_W-1:0]    s1_len_next;

    // chunk emitter
    logic                          s2_valid_reg, s2_valid_next;
    logic                          s2_phase_reg, s2_phase_next;
    logic [dgcp_pkg::WORD_W-1:0]   s2_word_reg, s2_word_next;
    logic [dgcp_pkg::LEN_W-1:0]    s2_len_reg;
    logic [dgcp_pkg::LEN_W-1:0]    shamt;

    // output register
    logic                          out_valid_reg, out_valid_next;
    dgcp_pkg::chunk_t              out_reg;

    logic             out_ready, emit, s2_ready, s2_load, s1_ready;
    logic             two_chunks;
    dgcp_pkg::chunk_t cur_chunk;

    assign out_ready = !out_valid_reg || pop;
    assign emit      = s2_valid_reg && out_ready;
    assign s2_ready  = !s2_valid_reg || (emit && cur_chunk.last);
    assign s2_load   = s1_valid_reg && s2_ready;
    assign s1_ready  = !s1_valid_reg || s2_load;
    assign head_pop  = !head_empty && s1_ready;

    always_comb
    begin
        if (head.is_raw)
            s1_len_next = dgcp_pkg::LEN_W'(head.raw_len);
        else
            s1_len_next = {floor_log2(head.value), 1'b1};
    end

    assign shamt        = dgcp_pkg::LEN_W'(dgcp_pkg::WORD_W - int'(s1_len_reg));
    assign s2_word_next = dgcp_pkg::WORD_W'(s1_value_reg) << shamt;
    assign two_chunks   = s2_len_reg > dgcp_pkg::LEN_W'(dgcp_pkg::CHUNK_WIDTH);

    always_comb
    begin
        if (!s2_phase_reg)
        begin
            cur_chunk.bits   = s2_word_reg[dgcp_pkg::WORD_W-1 -: dgcp_pkg::CHUNK_WIDTH];
            cur_chunk.length = two_chunks ? dgcp_pkg::LEN_W'(dgcp_pkg::CHUNK_WIDTH)
                                          : s2_len_reg;
            cur_chunk.last   = !two_chunks;
        end
        else
        begin
            cur_chunk.bits   = s2_word_reg[dgcp_pkg::CHUNK_WIDTH-1:0];
            cur_chunk.length = s2_len_reg - dgcp_pkg::LEN_W'(dgcp_pkg::CHUNK_WIDTH);
            cur_chunk.last   = 1'b1;
        end
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        s2_phase_next = s2_phase_reg;
        if (s2_load)
        begin
            s2_valid_next = 1'b1;
            s2_phase_next = 1'b0;
        end
        else if (emit)
        begin
            s2_valid_next = !cur_chunk.last;
            s2_phase_next = !cur_chunk.last;
        end
        out_valid_next = emit ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_phase_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= head_pop;
            s2_valid_reg  <= s2_valid_next;
            s2_phase_reg  <= s2_phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop)
        begin
            s1_value_reg <= head.value;
            s1_len_reg   <= s1_len_next;
        end
        if (s2_load)
        begin
            s2_word_reg <= s2_word_next;
            s2_len_reg  <= s1_len_reg;
        end
        if (emit)
            out_reg <= cur_chunk;
    end

    assign empty = !out_valid_reg;
    assign chunk = out_reg;

    a_phase_needs_long_word: assert property (@(posedge clk) disable iff (!rst_n)
        s2_phase_reg |-> s2_valid_reg && two_chunks)
        else $error("second chunk pending without a long codeword");

    a_split_sets_phase: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !cur_chunk.last |=> s2_phase_reg && s2_valid_reg)
        else $error("first of two chunks not followed by second");

    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> s1_len_reg != '0
            && s1_len_reg <= dgcp_pkg::LEN_W'(dgcp_pkg::MAX_WORD_LEN))
        else $error("codeword length out of range");

    a_out_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.length != '0
            && out_reg.length <= dgcp_pkg::LEN_W'(dgcp_pkg::CHUNK_WIDTH))
        else $error("chunk length out of range");

endmodule

/* hdl/delta_gamma_curve_code_packer.sv */
// delta_gamma_curve_code_packer: top level, front classifier, point queue
// and chunk back end. Depends on dgcp_pkg, dgcp_front, dgcp_fifo, dgcp_back.
//
// Packs one space-filling-curve code per point into Elias gamma chunks. The
// first point after reset, or any point with new_track set, goes out raw in
// code_bits bits; later points go out as the gamma codeword of the zigzag
// mapped delta plus one, left aligned in chunks of up to 64 bits with
// last_chunk on the final one. Points are pushed through push/full and
// chunks popped through empty/pop; a four-entry queue sits between the
// classifier and the chunk emitter, so the input keeps taking points while
// chunks wait at the output. A codeword of up to 64 bits takes one chunk, a
// longer one (delta codewords above 64 bits) takes two; the emitter puts
// out one chunk per cycle while the output is popped. A point's first chunk
// passes the queue, length stage, chunk emitter and output register. The
// user must write code_bits through cfg_wr_en and cfg_wr_data only while no
// point is in flight; the block does not enforce it. Zero acts as 1, 63 as 62.
module delta_gamma_curve_code_packer (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [dgcp_pkg::CB_W-1:0]           cfg_wr_data,
    // point side
    input  logic                                push,
    output logic                                full,
    input  logic [dgcp_pkg::CODE_W-1:0]         point_code,
    input  logic                                new_track,
    // chunk side
    output logic                                empty,
    input  logic                                pop,
    output logic [dgcp_pkg::CHUNK_WIDTH-1:0]    chunk_bits,
    output logic [dgcp_pkg::LEN_W-1:0]          chunk_length,
    output logic                                last_chunk
);

    logic              entry_wr;
    dgcp_pkg::entry_t  entry;
    dgcp_pkg::entry_t  head;
    logic              head_empty;
    logic              head_pop;
    dgcp_pkg::chunk_t  chunk;

    // front: masking, track state and delta mapping
    dgcp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .queue_full  (full),
        .point_code  (point_code),
        .new_track   (new_track),
        .entry_wr    (entry_wr),
        .entry       (entry)
    );

    // decoupling queue, its full flag is the input backpressure
    dgcp_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (entry_wr),
        .wr_data (entry),
        .rd_en   (head_pop),
        .rd_data (head),
        .full    (full),
        .empty   (head_empty)
    );

    // back: length, alignment and one chunk transaction per cycle while popped
    dgcp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_empty (head_empty),
        .head_pop   (head_pop),
        .pop        (pop),
        .empty      (empty),
        .chunk      (chunk)
    );

    assign chunk_bits   = chunk.bits;
    assign chunk_length = chunk.length;
    assign last_chunk   = chunk.last;

endmodule

/* dv/delta_gamma_curve_code_packer_tb.sv */
// delta_gamma_curve_code_packer_tb: self-checking bench for the curve code packer
// holds the chunk scoreboard, push/pop drivers and the stimulus sequence
// depends on dgcp_pkg and delta_gamma_curve_code_packer
`timescale 1ns / 1ps

module delta_gamma_curve_code_packer_tb;

    // random phase plan: code_bits per phase, last phase draws its own
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_POINTS = 175;
    localparam int PHASE_BITS [NUM_PHASES] = '{62, 1, 63, 0, 17, 62, 40, 8, 32, 33};
    localparam int PRESSURE_PHASE = 5;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 20;

    // predicts the chunk stream from each accepted point and checks what pops out
    class packer_scoreboard;
        logic [dgcp_pkg::CB_W-1:0]   code_bits;
        logic [dgcp_pkg::CODE_W-1:0] prev_code;
        bit                          track_open;
        dgcp_pkg::chunk_t            pending_chunks[$];
        int                          errors;
        int                          points;
        int                          raw_points;
        int                          split_points;
        int                          chunks;

        function new();
            code_bits    = dgcp_pkg::CODE_BITS_RESET;
            prev_code    = '0;
            track_open   = 1'b0;
            errors       = 0;
            points       = 0;
            raw_points   = 0;
            split_points = 0;
            chunks       = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // gamma code of zigzag(delta)+1, or the raw code on a track start
        function void note_point(logic [dgcp_pkg::CODE_W-1:0] code_in, logic start);
            int unsigned                 nb;
            int unsigned                 len;
            int unsigned                 lg;
            int                          i;
            logic [63:0]                 keep;
            logic [dgcp_pkg::CODE_W-1:0] code;
            logic [63:0]                 zz;
            logic [63:0]                 val;
            logic [127:0]                word;
            dgcp_pkg::chunk_t            c;
            nb = (code_bits == 0) ? 1
               : (code_bits > dgcp_pkg::MAX_CODE_BITS) ? dgcp_pkg::MAX_CODE_BITS
               : code_bits;
            keep = (64'd1 << nb) - 64'd1;
            code = code_in & keep[dgcp_pkg::CODE_W-1:0];
            points++;
            if (!track_open || start)
            begin
                word = 128'(code);
                len  = nb;
                raw_points++;
            end
            else
            begin
                if (code >= prev_code)
                    zz = {2'b00, code - prev_code} << 1;
                else
                    zz = ({2'b00, prev_code - code} << 1) - 64'd1;
                val = zz + 64'd1;
                lg  = 0;
                for (i = 0; i < 64; i++)
                    if (val[i])
                        lg = i;
                len  = 2 * lg + 1;
                word = 128'(val);
            end
            // left align the whole codeword, then cut it in two halves
            word = word << (128 - len);
            c.bits   = word[127:64];
            c.length = dgcp_pkg::LEN_W'(len > dgcp_pkg::CHUNK_WIDTH ? dgcp_pkg::CHUNK_WIDTH
                                                                     : len);
            c.last   = (len <= dgcp_pkg::CHUNK_WIDTH);
            pending_chunks = {pending_chunks, c};
            if (len > dgcp_pkg::CHUNK_WIDTH)
            begin
                c.bits   = word[63:0];
                c.length = dgcp_pkg::LEN_W'(len - dgcp_pkg::CHUNK_WIDTH);
                c.last   = 1'b1;
                pending_chunks = {pending_chunks, c};
                split_points++;
            end
            prev_code  = code;
            track_open = 1'b1;
        endfunction

        task check_chunk(logic [dgcp_pkg::CHUNK_WIDTH-1:0] bits,
                         logic [dgcp_pkg::LEN_W-1:0] len, logic last);
            dgcp_pkg::chunk_t want;
            chunks++;
            if (pending_chunks.size() == 0)
            begin
                report($sformatf("chunk %0d popped with nothing expected: bits %h length %0d",
                                 chunks, bits, len));
                return;
            end
            want = pending_chunks.pop_front();
            if (bits !== want.bits)
                report($sformatf("chunk %0d bits %h, want %h", chunks, bits, want.bits));
            if (len !== want.length)
                report($sformatf("chunk %0d length %0d, want %0d", chunks, len, want.length));
            if (last !== want.last)
                report($sformatf("chunk %0d last %b, want %b", chunks, last, want.last));
        endtask
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [dgcp_pkg::CB_W-1:0]        cfg_wr_data = '0;
    logic                             push = 1'b0;
    logic                             full;
    logic [dgcp_pkg::CODE_W-1:0]      point_code = '0;
    logic                             new_track = 1'b0;
    logic                             empty;
    logic                             pop = 1'b0;
    logic [dgcp_pkg::CHUNK_WIDTH-1:0] chunk_bits;
    logic [dgcp_pkg::LEN_W-1:0]       chunk_length;
    logic                             last_chunk;

    packer_scoreboard sb = new();

    // shared between the stimulus and the pop side
    bit                          tx_no_idle = 1'b0;
    bit                          rx_no_idle = 1'b0;
    bit                          hold_request = 1'b0;
    logic [dgcp_pkg::CODE_W-1:0] last_code = '0;
    int                          settings_used = 0;

    delta_gamma_curve_code_packer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .push         (push),
        .full         (full),
        .point_code   (point_code),
        .new_track    (new_track),
        .empty        (empty),
        .pop          (pop),
        .chunk_bits   (chunk_bits),
        .chunk_length (chunk_length),
        .last_chunk   (last_chunk)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one point, hold it until the transaction completes
    // push stays high on return so back-to-back points need no extra edge
    task automatic send_point(logic [dgcp_pkg::CODE_W-1:0] code, logic start);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push       <= 1'b1;
        point_code <= code;
        new_track  <= start;
        // full is read before the edge updates it, matching the accept rule
        do @(posedge clk); while (full);
        sb.note_point(code, start);
    endtask

    // code_bits may only change with nothing in flight
    // every point yields at least one chunk, so an empty scoreboard means idle
    task automatic write_code_bits(logic [dgcp_pkg::CB_W-1:0] value);
        push <= 1'b0;
        while (sb.pending_chunks.size() != 0) @(posedge clk);
        // let the emitter settle past its last chunk before the write
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.code_bits = value;
        settings_used++;
    endtask

    // mostly track-like codes with deltas of every magnitude, plus some noise
    function automatic logic [dgcp_pkg::CODE_W-1:0] next_code();
        int unsigned                 sel;
        int unsigned                 mag;
        logic [63:0]                 rnd;
        logic [dgcp_pkg::CODE_W-1:0] step;
        logic [dgcp_pkg::CODE_W-1:0] code;
        sel = $urandom_range(0, 99);
        rnd = {$urandom, $urandom};
        if (sel < 50)
        begin
            // small deltas dominate, large ones still show up
            mag  = $urandom_range(0, $urandom_range(0, dgcp_pkg::CODE_W));
            step = (mag == 0) ? '0 : rnd[dgcp_pkg::CODE_W-1:0] & ((62'd1 << mag) - 62'd1);
            code = $urandom_range(0, 1) ? last_code - step : last_code + step;
        end
        else if (sel < 65)
            code = rnd[dgcp_pkg::CODE_W-1:0];
        else if (sel < 75)
            code = last_code;
        else if (sel < 80)
            code = '0;
        else if (sel < 85)
            code = '1;
        else if (sel < 92)
            code = 62'd1 << $urandom_range(0, dgcp_pkg::CODE_W - 1);
        else
            code = last_code ^ (62'd1 << $urandom_range(0, dgcp_pkg::CODE_W - 1));
        last_code = code;
        return code;
    endfunction

    // pop side: random stalls, and one long hold-off so the queue backs up
    initial
    begin
        int gap;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            gap = rx_no_idle ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            sb.check_chunk(chunk_bits, chunk_length, last_chunk);
        end
    end

    // main sequence: directed corners, then random phases over several widths
    initial
    begin
        int                          p;
        logic [dgcp_pkg::CODE_W-1:0] code;
        logic                        start;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset width of 32: first point raw with high bits dropped
        send_point('1, 1'b0);
        // zero delta gives the one-bit codeword
        send_point('1, 1'b0);
        // masked wrap to zero, a large negative delta
        send_point('0, 1'b0);
        send_point(62'd1, 1'b0);
        send_point('0, 1'b0);
        send_point(62'd5, 1'b1);

        // full width: longest codewords in both directions
        write_code_bits(dgcp_pkg::CB_W'(dgcp_pkg::MAX_CODE_BITS));
        send_point('0, 1'b1);
        send_point('1, 1'b0);
        send_point('0, 1'b0);
        send_point(62'd1 << 61, 1'b0);
        send_point((62'd1 << 61) - 62'd1, 1'b0);
        send_point('1, 1'b1);

        // zero acts as one bit; the stored full-width code is kept mid track
        write_code_bits(dgcp_pkg::CB_W'(0));
        send_point('1, 1'b0);
        send_point(62'd2, 1'b0);
        send_point(62'd1, 1'b1);

        // 63 saturates to the maximum width
        write_code_bits(dgcp_pkg::CB_W'(63));
        send_point('1, 1'b0);
        send_point({31{2'b10}}, 1'b0);
        send_point({31{2'b01}}, 1'b1);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p == NUM_PHASES - 1)
                write_code_bits(dgcp_pkg::CB_W'($urandom_range(0, 63)));
            else
                write_code_bits(dgcp_pkg::CB_W'(PHASE_BITS[p]));
            // some phases run without gaps on one or both sides
            tx_no_idle = (p % 3 == 1) || (p == PRESSURE_PHASE);
            rx_no_idle = (p % 4 == 2);
            if (p == PRESSURE_PHASE)
                hold_request = 1'b1;
            repeat (PHASE_POINTS)
            begin
                code  = next_code();
                start = ($urandom_range(0, 19) == 0);
                send_point(code, start);
            end
        end

        push <= 1'b0;
        while (sb.pending_chunks.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending_chunks.size() != 0)
            sb.report($sformatf("%0d chunks never arrived", sb.pending_chunks.size()));

        $display("covered %0d points (%0d raw, %0d split over two chunks), %0d chunks checked",
                 sb.points, sb.raw_points, sb.split_points, sb.chunks);
        $display("code_bits written %0d times, %0d mismatches", settings_used, sb.errors);
        if (sb.errors == 0)
            $display("delta_gamma_curve_code_packer_tb passed");
        else
            $display("delta_gamma_curve_code_packer_tb failed");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("timeout waiting for the packer");
        $display("delta_gamma_curve_code_packer_tb failed");
        $finish;
    end

endmodule
